@@ rtl/core/rls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line stepper package
// Shared widths, request and step codes, and the payload types of both
// channels.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_point;
  } out_item_t;

endpackage

@@ rtl/core/raster_line_stepper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line stepper
// Integer line rasterizer that produces at most one pixel per request.
//
// A start transfer on the input channel carries both endpoints; the block
// emits the first endpoint and arms the line. Each advance transfer steps the
// line by one pixel and emits it, with last_point set on the final endpoint.
// An advance while no line is in progress is taken and produces nothing; a
// start aborts any line in progress. Every pixel carries draw_color, written
// through cfg_wr_en / cfg_wr_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// A pixel appears on the output channel in the cycle after its request is
// taken. Throughput is one request per cycle while the receiver takes each
// pixel; the step logic is a single add, compare and subtract between the
// line state and the output register. When the receiver stalls, the output
// register holds its pixel and in_ready drops until that pixel is taken.
//
// Reset clears the line state, draw_color and the output valid flag.
// ----------------------------------------------------------------------------
module raster_line_stepper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rls_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rls_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [rls_pkg::COLOR_BITS-1:0] cfg_wr_data
);

  localparam int CB = rls_pkg::COORD_BITS;
  localparam int EB = rls_pkg::ERR_BITS;

  function automatic logic [CB-1:0] move_coord(input logic [CB-1:0] c,
                                               input logic [1:0]    dir);
    logic [CB-1:0] r;
    begin
      case (dir)
        rls_pkg::DIR_PLUS:  r = c + 1'b1;
        rls_pkg::DIR_MINUS: r = c - 1'b1;
        default:            r = c;
      endcase
      return r;
    end
  endfunction

  logic [rls_pkg::COLOR_BITS-1:0] color_r;
  logic [CB-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [EB-1:0] err_r, err_nxt;
  logic [CB-1:0] adx_r, adx_nxt, ady_r, ady_nxt;
  logic [1:0]    dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic          x_major_r, x_major_nxt;
  logic [CB-1:0] steps_r, steps_nxt;
  logic          active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;
  rls_pkg::out_item_t out_r, out_nxt;

  logic          accept;
  logic [CB-1:0] s_adx, s_ady, s_major, s_minor;
  logic [1:0]    s_dir_x, s_dir_y;
  logic          s_x_major;
  logic [CB-1:0] a_major, a_minor, a_x, a_y;
  logic [EB-1:0] a_sum;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (in_data.end_x > in_data.start_x) begin
      s_dir_x = rls_pkg::DIR_PLUS;
      s_adx   = in_data.end_x - in_data.start_x;
    end else if (in_data.end_x < in_data.start_x) begin
      s_dir_x = rls_pkg::DIR_MINUS;
      s_adx   = in_data.start_x - in_data.end_x;
    end else begin
      s_dir_x = rls_pkg::DIR_NONE;
      s_adx   = '0;
    end
    if (in_data.end_y > in_data.start_y) begin
      s_dir_y = rls_pkg::DIR_PLUS;
      s_ady   = in_data.end_y - in_data.start_y;
    end else if (in_data.end_y < in_data.start_y) begin
      s_dir_y = rls_pkg::DIR_MINUS;
      s_ady   = in_data.start_y - in_data.end_y;
    end else begin
      s_dir_y = rls_pkg::DIR_NONE;
      s_ady   = '0;
    end
    s_x_major = s_adx > s_ady;
    s_major   = s_x_major ? s_adx : s_ady;
    s_minor   = s_x_major ? s_ady : s_adx;
  end

  always_comb begin
    a_major = x_major_r ? adx_r : ady_r;
    a_minor = x_major_r ? ady_r : adx_r;
    a_x     = x_major_r ? move_coord(cur_x_r, dir_x_r) : cur_x_r;
    a_y     = x_major_r ? cur_y_r : move_coord(cur_y_r, dir_y_r);
    a_sum   = err_r + {1'b0, a_minor};
  end

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    x_major_nxt   = x_major_r;
    steps_nxt     = steps_r;
    active_nxt    = active_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      if (in_data.req_type == rls_pkg::REQ_START) begin
        cur_x_nxt     = in_data.start_x;
        cur_y_nxt     = in_data.start_y;
        err_nxt       = {1'b0, s_minor};
        adx_nxt       = s_adx;
        ady_nxt       = s_ady;
        dir_x_nxt     = s_dir_x;
        dir_y_nxt     = s_dir_y;
        x_major_nxt   = s_x_major;
        steps_nxt     = s_major;
        active_nxt    = s_major != '0;
        out_valid_nxt = 1'b1;
      end else if (active_r) begin
        cur_x_nxt = a_x;
        cur_y_nxt = a_y;
        err_nxt   = a_sum;
        if (a_sum > {1'b0, a_major}) begin
          err_nxt = a_sum - {1'b0, a_major};
          if (x_major_r) begin
            cur_y_nxt = move_coord(cur_y_r, dir_y_r);
          end else begin
            cur_x_nxt = move_coord(cur_x_r, dir_x_r);
          end
        end
        steps_nxt     = steps_r - 1'b1;
        active_nxt    = steps_nxt != '0;
        out_valid_nxt = 1'b1;
      end
      out_nxt.pixel_x     = cur_x_nxt;
      out_nxt.pixel_y     = cur_y_nxt;
      out_nxt.pixel_color = color_r;
      out_nxt.last_point  = steps_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      adx_r       <= '0;
      ady_r       <= '0;
      dir_x_r     <= rls_pkg::DIR_NONE;
      dir_y_r     <= rls_pkg::DIR_NONE;
      x_major_r   <= 1'b0;
      steps_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      adx_r       <= adx_nxt;
      ady_r       <= ady_nxt;
      dir_x_r     <= dir_x_nxt;
      dir_y_r     <= dir_y_nxt;
      x_major_r   <= x_major_nxt;
      steps_r     <= steps_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

@@ rtl/core/rls_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line stepper checker
// Port-level assertions on reset, flow control and start transfers.
// ----------------------------------------------------------------------------
module rls_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rls_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rls_pkg::out_item_t  out_data
);

  logic start_xfer;
  logic single_pt;

  assign start_xfer = in_valid && in_ready && in_data.req_type == rls_pkg::REQ_START;
  assign single_pt  = in_data.start_x == in_data.end_x && in_data.start_y == in_data.end_y;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_start_point: assert property (@(posedge clk) disable iff (!rst_n)
    start_xfer |=> out_valid && out_data.pixel_x == $past(in_data.start_x)
                  && out_data.pixel_y == $past(in_data.start_y))
    else $error("start transfer did not emit its first endpoint");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    start_xfer && single_pt |=> out_data.last_point)
    else $error("single-point line not marked last");

endmodule

bind raster_line_stepper rls_checker u_rls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
